/* rtl/tsac_pkg.sv */
`default_nettype none

package tsac_pkg;

   localparam int PROB_W  = 25;
   localparam int IDX_W   = 16;
   localparam int CDF_W   = 41;
   localparam int DRAW_W  = 24;
   localparam int RNG_W   = 64;
   localparam int HALF_W  = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [IDX_W-1:0]  IDX_MAX   = {IDX_W{1'b1}};
   localparam logic [CDF_W-1:0]  CDF_MAX   = {CDF_W{1'b1}};
   localparam logic [RNG_W-1:0]  SEED_RST  = 64'd1;
   localparam logic [RNG_W-1:0]  MIX_MULT  = 64'h2545_F491_4F6C_DD1D;
   localparam logic [HALF_W-1:0] MIX_LO    = MIX_MULT[HALF_W-1:0];
   localparam logic [HALF_W-1:0] MIX_HI    = MIX_MULT[RNG_W-1:HALF_W];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_MODE = 1'b0,
      CSR_SEED        = 1'b1
   } csr_index_type;

   // partial products of the 64-bit state times the mix constant
   typedef struct packed {
      logic [2*HALF_W-1:0] lo_lo;
      logic [HALF_W-1:0]   hi_lo;
      logic [HALF_W-1:0]   lo_hi;
   } mix_prod_type;

   function automatic logic [RNG_W-1:0] xs_step(input logic [RNG_W-1:0] s);
      logic [RNG_W-1:0] t;
      t = s ^ (s >> 12);
      t = t ^ (t << 25);
      t = t ^ (t >> 27);
      return t;
   endfunction

   function automatic mix_prod_type mix_products(input logic [RNG_W-1:0] s);
      mix_prod_type  p;
      logic [2*HALF_W-1:0] a;
      logic [2*HALF_W-1:0] b;
      p.lo_lo = s[HALF_W-1:0] * MIX_LO;
      a       = s[RNG_W-1:HALF_W] * MIX_LO;
      b       = s[HALF_W-1:0] * MIX_HI;
      p.hi_lo = a[HALF_W-1:0];
      p.lo_hi = b[HALF_W-1:0];
      return p;
   endfunction

   // bits 63..32 of the low product word, then bits 31..8 of that
   function automatic logic [DRAW_W-1:0] mix_draw(input mix_prod_type p);
      logic [HALF_W-1:0] w;
      w = p.lo_lo[2*HALF_W-1:HALF_W] + p.hi_lo + p.lo_hi;
      return w[HALF_W-1:HALF_W-DRAW_W];
   endfunction

endpackage

`default_nettype wire

/* rtl/token_sampler_argmax_or_cdf.sv */
`default_nettype none

// channel  direction  handshake           payload
// req      in         req_valid/req_stall req_prob[24:0], req_last_item
// rsp      out        rsp_valid/rsp_stall rsp_token_index[15:0]
// csr      in         csr_valid/csr_ready csr_index[0], csr_wdata[63:0]
//
// one word per cycle while req_stall is low; the token index is registered and shows in
// the cycle after the last word of a vector. the generator draw is computed ahead of use
// in a two-stage multiply pipeline, so after reset and after each seed write the block
// holds req_stall while that pipeline refills.
// req_stall also follows rsp_stall while a result waits to be taken.
// reset is synchronous; csr writes are always taken.
module token_sampler_argmax_or_cdf
   import tsac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PROB_W-1:0]    req_prob,
   input  wire logic                 req_last_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [IDX_W-1:0]          rsp_token_index,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [RNG_W-1:0]     csr_wdata
);

   logic                 mode_ff, mode_in;
   logic [RNG_W-1:0]     rng_ff, rng_in;
   logic [DRAW_W-1:0]    draw_next_ff, draw_next_in;
   mix_prod_type         prod_ff, prod_in;
   logic [1:0]           prime_ff, prime_in;
   logic [DRAW_W-1:0]    draw_value_ff, draw_value_in;
   logic [CDF_W-1:0]     cdf_ff, cdf_in;
   logic                 picked_ff, picked_in;
   logic [IDX_W-1:0]     picked_idx_ff, picked_idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [PROB_W-1:0]    best_val_ff, best_val_in;
   logic [IDX_W-1:0]     top_idx_ff, top_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;

   logic                 accept, csr_wr, first, draw_now;
   logic [DRAW_W-1:0]    dv;
   logic [CDF_W:0]       cdf_wide;
   logic [CDF_W-1:0]     cdf_sat;
   logic                 pick_now;
   logic [RNG_W-1:0]     xs1, xs2, xs3;
   logic [IDX_W-1:0]     result;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign req_stall = (prime_ff != 2'd0) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_token_index = rsp_idx_ff;

   assign xs1 = xs_step(rng_ff);
   assign xs2 = xs_step(xs1);
   assign xs3 = xs_step(xs2);

   assign first    = (pos_ff == '0);
   assign draw_now = accept & first & mode_ff;
   assign dv       = (first & mode_ff) ? draw_next_ff : draw_value_ff;

   always_comb begin
      cdf_wide = {1'b0, cdf_ff} + {{(CDF_W+1-PROB_W){1'b0}}, req_prob};
      cdf_sat  = cdf_wide[CDF_W] ? CDF_MAX : cdf_wide[CDF_W-1:0];
      pick_now = ~picked_ff & ({{(CDF_W-DRAW_W){1'b0}}, dv} < cdf_sat);
   end

   always_comb begin
      mode_in       = mode_ff;
      rng_in        = rng_ff;
      draw_next_in  = draw_next_ff;
      prod_in       = prod_ff;
      prime_in      = prime_ff;
      draw_value_in = draw_value_ff;
      cdf_in        = cdf_ff;
      picked_in     = picked_ff;
      picked_idx_in = picked_idx_ff;
      pos_in        = pos_ff;
      best_val_in   = best_val_ff;
      top_idx_in    = top_idx_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_idx_in    = rsp_idx_ff;
      result        = top_idx_ff;

      // draw lookahead: draw_next is for xs(rng), prod_ff for xs(xs(rng))
      unique case (prime_ff)
         2'd2: begin
            prod_in  = mix_products(xs1);
            prime_in = 2'd1;
         end
         2'd1: begin
            draw_next_in = mix_draw(prod_ff);
            prod_in      = mix_products(xs2);
            prime_in     = 2'd0;
         end
         default: begin
            if (draw_now) begin
               rng_in        = xs1;
               draw_value_in = draw_next_ff;
               draw_next_in  = mix_draw(prod_ff);
               prod_in       = mix_products(xs3);
            end
         end
      endcase

      if (accept) begin
         if (first || req_prob > best_val_ff) begin
            best_val_in = req_prob;
            top_idx_in  = pos_ff;
         end
         cdf_in = cdf_sat;
         if (pick_now) begin
            picked_in     = 1'b1;
            picked_idx_in = pos_ff;
         end
         if (req_last_item) begin
            if (mode_ff) begin
               result = picked_in ? picked_idx_in : pos_ff;
            end else begin
               result = top_idx_in;
            end
            rsp_valid_in  = 1'b1;
            rsp_idx_in    = result;
            cdf_in        = '0;
            picked_in     = 1'b0;
            picked_idx_in = '0;
            pos_in        = '0;
            best_val_in   = '0;
            top_idx_in    = '0;
         end else if (pos_ff != IDX_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_MODE: mode_in = csr_wdata[0];
            CSR_SEED: begin
               rng_in   = csr_wdata;
               prime_in = 2'd2;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         rng_ff        <= SEED_RST;
         prime_ff      <= 2'd2;
         draw_value_ff <= '0;
         cdf_ff        <= '0;
         picked_ff     <= 1'b0;
         picked_idx_ff <= '0;
         pos_ff        <= '0;
         best_val_ff   <= '0;
         top_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         rng_ff        <= rng_in;
         prime_ff      <= prime_in;
         draw_value_ff <= draw_value_in;
         cdf_ff        <= cdf_in;
         picked_ff     <= picked_in;
         picked_idx_ff <= picked_idx_in;
         pos_ff        <= pos_in;
         best_val_ff   <= best_val_in;
         top_idx_ff    <= top_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      draw_next_ff <= draw_next_in;
      prod_ff      <= prod_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   // input held off while the draw lookahead refills
   a_prime_stall: assert property (@(posedge clock) disable iff (reset)
      (prime_ff != 2'd0) |-> req_stall)
      else $error("word taken while draw pipeline not primed");

   a_seed_stall: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_SEED) |=> req_stall)
      else $error("no refill stall after seed write");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_item))
      else $error("result without a last word");

   a_vec_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_item) |=> (pos_ff == '0 && !picked_ff))
      else $error("vector state not cleared after last word");

endmodule

`default_nettype wire

/* sim/token_sampler_argmax_or_cdf_tb.sv */
`timescale 1ns / 100ps

import tsac_pkg::*;

// tracks both the argmax and the running cdf for each vector and queues the chosen index
class token_choice_board;
   localparam logic [40:0] CDF_TOP   = {41{1'b1}};
   localparam logic [63:0] SCRAMBLER = 64'h2545_F491_4F6C_DD1D;

   bit                 mode;
   logic [RNG_W-1:0]   rng;
   logic [23:0]        draw;
   logic [40:0]        cdf;
   bit                 picked;
   logic [IDX_W-1:0]   picked_idx;
   logic [IDX_W-1:0]   pos;
   logic [PROB_W-1:0]  best_val;
   logic [IDX_W-1:0]   top_idx;
   logic [IDX_W-1:0]   chosen_index_q[$];
   int                 mismatches;

   function new();
      mode = 1'b0;
      rng = 64'd1;
      draw = '0;
      mismatches = 0;
      clear_vector();
   endfunction

   function void clear_vector();
      cdf = '0;
      picked = 1'b0;
      picked_idx = '0;
      pos = '0;
      best_val = '0;
      top_idx = '0;
   endfunction

   function int pending();
      return chosen_index_q.size();
   endfunction

   function void write_reg(csr_index_type which, logic [RNG_W-1:0] value);
      case (which)
         CSR_SAMPLE_MODE: mode = value[0];
         CSR_SEED:        rng = value;
         default:         ;
      endcase
   endfunction

   // xorshift step, then bits 31..8 of the upper half of the scrambled product
   function logic [23:0] next_draw();
      logic [63:0] s;
      logic [63:0] prod;
      s = rng;
      s ^= s >> 12;
      s ^= s << 25;
      s ^= s >> 27;
      rng = s;
      prod = s * SCRAMBLER;
      return prod[63:40];
   endfunction

   function void note_word(logic [PROB_W-1:0] p, bit last);
      logic [IDX_W-1:0] idx;
      logic [40:0]      wide;
      bit               first;
      first = (pos == 0);
      idx = pos;
      wide = 41'(p);
      if (first && mode)
         draw = next_draw();
      if (first || p > best_val) begin
         best_val = p;
         top_idx = idx;
      end
      if (cdf > CDF_TOP - wide)
         cdf = CDF_TOP;
      else
         cdf = cdf + wide;
      if (!picked && 41'(draw) < cdf) begin
         picked = 1'b1;
         picked_idx = idx;
      end
      if (last) begin
         if (mode)
            chosen_index_q.push_back(picked ? picked_idx : idx);
         else
            chosen_index_q.push_back(top_idx);
         clear_vector();
      end else if (pos != {IDX_W{1'b1}}) begin
         pos = pos + 1'b1;
      end
   endfunction

   task report(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
      $display("mismatch: %s, got %0d, want %0d", what, got, want);
      mismatches++;
   endtask

   task check_token(logic [IDX_W-1:0] got);
      logic [IDX_W-1:0] want;
      if (chosen_index_q.size() == 0) begin
         report("token index with no vector pending", got, '0);
      end else begin
         want = chosen_index_q.pop_front();
         if (got !== want)
            report("token index", got, want);
      end
   endtask
endclass

module token_sampler_argmax_or_cdf_tb;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_type;
   typedef enum int {PROB_SHARE, PROB_FULL, PROB_TIES, PROB_EDGE} prob_style_type;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PROB_W-1:0]    req_prob;
   logic                 req_last_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [IDX_W-1:0]     rsp_token_index;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RNG_W-1:0]     csr_wdata;

   token_choice_board book = new();

   int burst_left = 0;
   int hold_asked = 0;
   int quiet_cycles = 0;

   token_sampler_argmax_or_cdf dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_prob        (req_prob),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_index (rsp_token_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            book.check_token(rsp_token_index);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver stall pattern, plus long hold-offs on request
   initial begin
      stall_pattern_type pattern;
      int pattern_left;
      int tick;
      int hold_left;
      int hold_seen;
      pattern = STALL_NONE;
      pattern_left = 0;
      tick = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (pattern_left == 0) begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(32, 256);
         end
         pattern_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (tick % 5 < 2);
            endcase
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [PROB_W-1:0] prob, input bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_prob <= prob;
      req_last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_word(prob, last);
      burst_left--;
      @(negedge clock);
   endtask

   // waits for all results and lets the block idle before touching a register
   task automatic set_reg(input csr_index_type which, input logic [RNG_W-1:0] value);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_reg(which, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PROB_W-1:0] pick_prob(prob_style_type style, int len);
      case (style)
         PROB_SHARE: return PROB_W'($urandom_range(0, 2 * 16777216 / len));
         PROB_FULL:  return PROB_W'($urandom());
         PROB_TIES:  return PROB_W'($urandom_range(0, 3)) << 20;
         default: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return PROB_W'(1);
               2:       return PROB_W'(16777216);
               3:       return PROB_W'(16777215);
               default: return {PROB_W{1'b1}};
            endcase
         end
      endcase
   endfunction

   task automatic send_vector(input int len);
      prob_style_type style;
      int r;
      r = $urandom_range(0, 9);
      style = (r < 6) ? PROB_SHARE : (r < 8) ? PROB_FULL : (r == 8) ? PROB_TIES : PROB_EDGE;
      for (int i = 0; i < len; i++)
         send_word(pick_prob(style, len), i == len - 1);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 1;
      else if (r == 9)
         return $urandom_range(11, 40);
      else
         return $urandom_range(2, 10);
   endfunction

   initial begin
      int sent;
      int len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_prob = '0;
      req_last_item = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_MODE;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // greedy out of reset: ties keep the earliest maximum
      send_word(25'd7, 1'b0);
      send_word(25'h1FF_FFFF, 1'b0);
      send_word(25'h1FF_FFFF, 1'b0);
      send_word(25'd16777216, 1'b0);
      send_word(25'd0, 1'b1);
      send_word(25'd0, 1'b1);

      // sampling from the reset seed, including a sum that never passes the draw
      set_reg(CSR_SAMPLE_MODE, 64'd1);
      send_word(25'd16777216, 1'b0);
      send_word(25'd0, 1'b1);
      send_word(25'd0, 1'b0);
      send_word(25'd0, 1'b0);
      send_word(25'd0, 1'b1);
      send_word(25'd8388608, 1'b0);
      send_word(25'd8388608, 1'b0);
      send_word(25'd1, 1'b1);

      // mode flips in the middle of a vector
      send_word(25'd4194304, 1'b0);
      send_word(25'h1FF_FFFF, 1'b0);
      set_reg(CSR_SAMPLE_MODE, 64'd0);
      send_word(25'd5, 1'b1);
      send_word(25'd0, 1'b0);
      set_reg(CSR_SAMPLE_MODE, 64'd1);
      send_word(25'd0, 1'b0);
      send_word(25'd16777216, 1'b1);

      // zero seed keeps every draw at zero
      set_reg(CSR_SEED, 64'd0);
      send_word(25'd0, 1'b0);
      send_word(25'd1, 1'b0);
      send_word(25'd0, 1'b1);
      set_reg(CSR_SEED, {RNG_W{1'b1}});
      send_word(25'd8388608, 1'b0);
      send_word(25'd8388608, 1'b1);

      for (int phase = 0; phase < 10; phase++) begin
         set_reg(CSR_SAMPLE_MODE, (phase % 3 != 0) ? 64'd1 : 64'd0);
         if (phase == 4)
            set_reg(CSR_SEED, 64'd0);
         else if (phase == 7)
            set_reg(CSR_SEED, {RNG_W{1'b1}});
         else if (phase % 3 == 1)
            set_reg(CSR_SEED, {$urandom(), $urandom()});
         if (phase == 5)
            hold_asked <= hold_asked + 1;
         sent = 0;
         while (sent < 65) begin
            len = (phase == 5) ? $urandom_range(1, 2) : pick_length();
            send_vector(len);
            sent += len;
         end
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (book.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tsac_pkg.sv
rtl/token_sampler_argmax_or_cdf.sv
sim/token_sampler_argmax_or_cdf_tb.sv
